// ===== hw/rtl/imu_heading_frame_decoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// IMU heading frame decoder assertion macros
// Shared assertion forms for the decoder RTL, clocked on clk with rst_n.
// ----------------------------------------------------------------------------
`ifndef IMU_HEADING_FRAME_DECODER_CORE_MACROS_SVH
`define IMU_HEADING_FRAME_DECODER_CORE_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define IHFD_ASSERT_NOW(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The antecedent in one cycle implies the consequent in the next.
`define IHFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ihfd_pkg.sv =====
// ----------------------------------------------------------------------------
// IMU heading frame decoder package
// Frame phase type, look mode codes and the assembled frame word bundle.
// ----------------------------------------------------------------------------
package ihfd_pkg;

    // Frame phase: idle, waiting for data byte 1..6, waiting for the trailer.
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_D1    = 3'd1,
        PH_D2    = 3'd2,
        PH_D3    = 3'd3,
        PH_D4    = 3'd4,
        PH_D5    = 3'd5,
        PH_D6    = 3'd6,
        PH_TRAIL = 3'd7
    } frame_phase_t;

    localparam logic [7:0] HDR_BYTE = 8'hAA;

    localparam logic [1:0] LOOK_NORTH = 2'd0;
    localparam logic [1:0] LOOK_WEST  = 2'd1;
    localparam logic [1:0] LOOK_EAST  = 2'd2;
    localparam logic [1:0] LOOK_SOUTH = 2'd3;

    typedef struct packed {
        logic signed [15:0] heading;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } frame_words_t;

endpackage

// ===== hw/rtl/ihfd_frame_asm.sv =====
// ----------------------------------------------------------------------------
// IMU heading frame assembler
// Tracks the frame phase, stores data bytes and registers the three words.
// ----------------------------------------------------------------------------
`include "imu_heading_frame_decoder_core_macros.svh"

module ihfd_frame_asm (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [7:0]            sensor_byte,
    output logic                  in_stall,
    input  logic                  words_take,
    output logic                  words_valid,
    output ihfd_pkg::frame_words_t words
);
    import ihfd_pkg::*;

    frame_phase_t phase_reg;
    frame_phase_t phase_next;

    logic [7:0]   byte_reg [5];
    logic         words_valid_reg;
    logic         words_valid_next;
    frame_words_t words_reg;

    logic         accept;
    logic         byte_wr_en;
    logic [2:0]   byte_idx;
    logic         load_words;

    assign accept = in_valid && !in_stall;

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_IDLE:  phase_next = (sensor_byte == HDR_BYTE) ? PH_D1 : PH_IDLE;
                PH_D1:    phase_next = PH_D2;
                PH_D2:    phase_next = PH_D3;
                PH_D3:    phase_next = PH_D4;
                PH_D4:    phase_next = PH_D5;
                PH_D5:    phase_next = PH_D6;
                PH_D6:    phase_next = PH_TRAIL;
                PH_TRAIL: phase_next = PH_IDLE;
                default:  phase_next = PH_IDLE;
            endcase
        end
    end

    // Phase outputs. Only the last data byte needs room in the word register.
    always_comb
    begin
        in_stall   = 1'b0;
        byte_wr_en = 1'b0;
        byte_idx   = 3'd0;
        load_words = 1'b0;
        unique case (phase_reg)
            PH_D1:
            begin
                byte_wr_en = accept;
                byte_idx   = 3'd0;
            end
            PH_D2:
            begin
                byte_wr_en = accept;
                byte_idx   = 3'd1;
            end
            PH_D3:
            begin
                byte_wr_en = accept;
                byte_idx   = 3'd2;
            end
            PH_D4:
            begin
                byte_wr_en = accept;
                byte_idx   = 3'd3;
            end
            PH_D5:
            begin
                byte_wr_en = accept;
                byte_idx   = 3'd4;
            end
            PH_D6:
            begin
                in_stall   = words_valid_reg && !words_take;
                load_words = accept;
            end
            default:
            begin
                in_stall = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (load_words)
            words_valid_next = 1'b1;
        else if (words_take)
            words_valid_next = 1'b0;
        else
            words_valid_next = words_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            words_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            words_valid_reg <= words_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_wr_en)
            byte_reg[byte_idx] <= sensor_byte;
        if (load_words)
        begin
            words_reg.heading <= {byte_reg[0], byte_reg[1]};
            words_reg.pitch   <= {byte_reg[2], byte_reg[3]};
            words_reg.roll    <= {byte_reg[4], sensor_byte};
        end
    end

    assign words_valid = words_valid_reg;
    assign words       = words_reg;

    `IHFD_ASSERT_NOW(a_stall_only_on_last_byte, !in_stall || (phase_reg == PH_D6 && words_valid_reg), "input stalled outside the last data byte")
    `IHFD_ASSERT_NEXT(a_last_byte_loads_words, accept && phase_reg == PH_D6, words_valid_reg && phase_reg == PH_TRAIL, "last data byte did not load the frame words")
    `IHFD_ASSERT_NOW(a_words_from_last_byte, !$rose(words_valid_reg) || $past(phase_reg == PH_D6), "frame words appeared without a last data byte")

endmodule

// ===== hw/rtl/ihfd_angle_calc.sv =====
// ----------------------------------------------------------------------------
// IMU heading angle calculator
// Converts the frame words to whole degrees, remaps heading, holds the result.
// ----------------------------------------------------------------------------
module ihfd_angle_calc (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  words_valid,
    input  ihfd_pkg::frame_words_t words,
    output logic                  words_take,
    input  logic [1:0]            look_mode,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [8:0]     heading_deg,
    output logic signed [15:0]    heading_centideg,
    output logic signed [9:0]     pitch_deg,
    output logic signed [9:0]     roll_deg
);
    import ihfd_pkg::*;

    // Division by 100, truncated toward zero: the magnitude is multiplied by
    // 5243 / 2^19, which is exact for every magnitude up to 32768.
    function automatic logic signed [9:0] div100(input logic signed [15:0] w);
        logic [15:0] mag;
        logic [28:0] prod;
        logic [9:0]  q;
        mag  = w[15] ? 16'(-w) : 16'(w);
        prod = 29'(mag) * 29'd5243;
        q    = prod[28:19];
        return w[15] ? 10'(-q) : 10'(q);
    endfunction

    logic signed [9:0]  head_whole;
    logic signed [10:0] head_remap;
    logic signed [10:0] head_wrap;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [8:0]  heading_deg_reg;
    logic signed [15:0] heading_centideg_reg;
    logic signed [9:0]  pitch_deg_reg;
    logic signed [9:0]  roll_deg_reg;

    assign words_take = !out_valid_reg || !out_stall;
    assign head_whole = div100(words.heading);

    always_comb
    begin
        head_remap = 11'(head_whole);
        case (look_mode)
            LOOK_WEST:  head_remap = 11'(head_whole) - 11'sd90;
            LOOK_EAST:  head_remap = 11'(head_whole) + 11'sd90;
            LOOK_SOUTH:
            begin
                if (head_whole > 10'sd0)
                    head_remap = 11'(head_whole) - 11'sd180;
                else
                    head_remap = 11'(head_whole) + 11'sd180;
            end
            default:    head_remap = 11'(head_whole);
        endcase
    end

    always_comb
    begin
        if (head_remap > 11'sd180)
            head_wrap = head_remap - 11'sd360;
        else if (head_remap < -11'sd180)
            head_wrap = head_remap + 11'sd360;
        else
            head_wrap = head_remap;
    end

    always_comb
    begin
        if (words_take)
            out_valid_next = words_valid;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (words_take && words_valid)
        begin
            heading_deg_reg      <= head_wrap[8:0];
            heading_centideg_reg <= words.heading;
            pitch_deg_reg        <= div100(words.pitch);
            roll_deg_reg         <= div100(words.roll);
        end
    end

    assign out_valid        = out_valid_reg;
    assign heading_deg      = heading_deg_reg;
    assign heading_centideg = heading_centideg_reg;
    assign pitch_deg        = pitch_deg_reg;
    assign roll_deg         = roll_deg_reg;

endmodule

// ===== hw/rtl/imu_heading_frame_decoder_core.sv =====
// A result is offered once the converted angles are registered: the edge that takes the sixth data
// byte loads the frame word register, and the result register loads from it once it has room.
// Throughput: one sensor byte per cycle; the last data byte of a frame waits only while the
// frame word register and the result register are both full and the result is stalled.
// Reset clears the frame phase, both valid flags and look_mode (north).
// ----------------------------------------------------------------------------
// IMU heading frame decoder core
// Decodes orientation sensor frames into heading, pitch and roll in degrees.
// ----------------------------------------------------------------------------
module imu_heading_frame_decoder_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         sensor_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [8:0]  heading_deg,
    output logic signed [15:0] heading_centideg,
    output logic signed [9:0]  pitch_deg,
    output logic signed [9:0]  roll_deg
);
    import ihfd_pkg::*;

    logic [1:0]   look_mode_reg;
    logic [1:0]   look_mode_next;
    logic         words_valid;
    logic         words_take;
    frame_words_t words;

    assign look_mode_next = cfg_wr_en ? cfg_wr_data : look_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            look_mode_reg <= LOOK_NORTH;
        else
            look_mode_reg <= look_mode_next;
    end

    ihfd_frame_asm u_frame_asm (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .sensor_byte (sensor_byte),
        .in_stall    (in_stall),
        .words_take  (words_take),
        .words_valid (words_valid),
        .words       (words)
    );

    ihfd_angle_calc u_angle_calc (
        .clk              (clk),
        .rst_n            (rst_n),
        .words_valid      (words_valid),
        .words            (words),
        .words_take       (words_take),
        .look_mode        (look_mode_reg),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .heading_deg      (heading_deg),
        .heading_centideg (heading_centideg),
        .pitch_deg        (pitch_deg),
        .roll_deg         (roll_deg)
    );

endmodule

// ===== test/imu_heading_frame_decoder_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IMU heading frame decoder core testbench
// Streams sensor bytes into the decoder (a short directed set, then mostly
// well-formed frames with random content mixed with noise and cut-off frames)
// under random idling on both channels, predicts every decoded frame and
// compares each result field by field.
// ----------------------------------------------------------------------------
module imu_heading_frame_decoder_core_test;

    import ihfd_pkg::*;

    localparam int CENTIDEG_PER_DEG = 100;
    localparam int QUARTER_TURN     = 90;
    localparam int HALF_TURN        = 180;
    localparam int FULL_TURN        = 360;
    localparam int HOLD_AT_RESULT   = 25;
    localparam int HOLD_CYCLES      = 80;

    typedef struct {
        logic signed [8:0]  heading_deg;
        logic signed [15:0] heading_centideg;
        logic signed [9:0]  pitch_deg;
        logic signed [9:0]  roll_deg;
    } attitude_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_wr_data = LOOK_NORTH;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         sensor_byte = 8'h00;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [8:0]  heading_deg;
    logic signed [15:0] heading_centideg;
    logic signed [9:0]  pitch_deg;
    logic signed [9:0]  roll_deg;

    // Sensor byte requests waiting to be offered, and decoded frames still due.
    logic [7:0]   pending_bytes[$];
    attitude_t    attitude_due[$];
    attitude_t    attitude_want;

    // Predictor state: frame position, held data bytes and the look mode.
    frame_phase_t phase_now = PH_IDLE;
    logic [7:0]   held_bytes[5];
    logic [1:0]   look_now = LOOK_NORTH;

    int send_idle_pct = 36;
    int recv_idle_pct = 66;
    int mismatches = 0;
    int results_seen = 0;
    int hold_left = 0;

    logic [1:0] batch_look[6] = '{LOOK_NORTH, LOOK_SOUTH, LOOK_WEST,
                                  LOOK_EAST, LOOK_SOUTH, LOOK_NORTH};

    imu_heading_frame_decoder_core i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sensor_byte      (sensor_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .heading_deg      (heading_deg),
        .heading_centideg (heading_centideg),
        .pitch_deg        (pitch_deg),
        .roll_deg         (roll_deg)
    );

    always #6 clk = ~clk;

    function automatic void decode_sensor_byte(input logic [7:0] b);
        int        head_cd;
        int        pitch_cd;
        int        roll_cd;
        int        head_deg;
        attitude_t att;
        case (phase_now)
            PH_IDLE:
            begin
                if (b == HDR_BYTE)
                    phase_now = PH_D1;
            end
            PH_TRAIL:
                phase_now = PH_IDLE;
            PH_D6:
            begin
                head_cd  = $signed({held_bytes[0], held_bytes[1]});
                pitch_cd = $signed({held_bytes[2], held_bytes[3]});
                roll_cd  = $signed({held_bytes[4], b});
                head_deg = head_cd / CENTIDEG_PER_DEG;
                case (look_now)
                    LOOK_WEST:  head_deg = head_deg - QUARTER_TURN;
                    LOOK_EAST:  head_deg = head_deg + QUARTER_TURN;
                    LOOK_SOUTH: head_deg = (head_deg > 0) ? head_deg - HALF_TURN
                                                          : head_deg + HALF_TURN;
                    default:    head_deg = head_deg;
                endcase
                // A single wrap is enough, since the remap moves by at most half a turn.
                if (head_deg > HALF_TURN)
                    head_deg = head_deg - FULL_TURN;
                if (head_deg < -HALF_TURN)
                    head_deg = head_deg + FULL_TURN;
                att.heading_deg      = head_deg[8:0];
                att.heading_centideg = head_cd[15:0];
                att.pitch_deg        = 10'(pitch_cd / CENTIDEG_PER_DEG);
                att.roll_deg         = 10'(roll_cd / CENTIDEG_PER_DEG);
                attitude_due.push_back(att);
                phase_now = PH_TRAIL;
            end
            default:
            begin
                held_bytes[int'(phase_now) - 1] = b;
                phase_now = frame_phase_t'(phase_now + 3'd1);
            end
        endcase
    endfunction

    function automatic logic [15:0] random_angle_word();
        int v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = int'($urandom_range(36000)) - 18000;
            2: v = int'($urandom_range(200)) - 100;
            default:
            begin
                case ($urandom_range(3))
                    0: v = 32'h8000;
                    1: v = 32'h7FFF;
                    2: v = 18000;
                    default: v = -18000;
                endcase
            end
        endcase
        return v[15:0];
    endfunction

    task automatic push_frame(input logic [15:0] head, input logic [15:0] pitch,
                              input logic [15:0] roll, input logic [7:0] trailer);
        pending_bytes.push_back(HDR_BYTE);
        pending_bytes.push_back(head[15:8]);
        pending_bytes.push_back(head[7:0]);
        pending_bytes.push_back(pitch[15:8]);
        pending_bytes.push_back(pitch[7:0]);
        pending_bytes.push_back(roll[15:8]);
        pending_bytes.push_back(roll[7:0]);
        pending_bytes.push_back(trailer);
    endtask

    task automatic queue_random_traffic(input int n_items);
        int count;
        int pick;
        int cut_len;
        count = 0;
        while (count < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                push_frame(random_angle_word(), random_angle_word(), random_angle_word(),
                           8'($urandom_range(255)));
                count = count + 8;
            end
            else if (pick < 92)
            begin
                pending_bytes.push_back(8'($urandom_range(255)));
                count = count + 1;
            end
            else
            begin
                // A frame cut short; the next header is then taken as data.
                cut_len = $urandom_range(1, 5);
                pending_bytes.push_back(HDR_BYTE);
                repeat (cut_len)
                    pending_bytes.push_back(8'($urandom_range(255)));
                count = count + 1 + cut_len;
            end
        end
    endtask

    task automatic wait_until_quiet();
        while (pending_bytes.size() != 0 || in_valid || attitude_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_look(input logic [1:0] mode);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        look_now = mode;
        @(negedge clk);
    endtask

    // Sender: a request is held unchanged until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            sensor_byte <= 8'h00;
        end
        else
        begin
            if (in_valid && !in_stall)
                decode_sensor_byte(sensor_byte);
            if (!in_valid || !in_stall)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid    <= 1'b1;
                    sensor_byte <= pending_bytes.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result and, once, holds off long enough to back up the block.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen = results_seen + 1;
                if (results_seen == HOLD_AT_RESULT)
                    hold_left = HOLD_CYCLES;
                if (attitude_due.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result %0d: hdg %0d cdeg %0d pitch %0d roll %0d",
                                 results_seen, heading_deg, heading_centideg,
                                 pitch_deg, roll_deg);
                end
                else
                begin
                    attitude_want = attitude_due.pop_front();
                    if (heading_deg !== attitude_want.heading_deg
                        || heading_centideg !== attitude_want.heading_centideg
                        || pitch_deg !== attitude_want.pitch_deg
                        || roll_deg !== attitude_want.roll_deg)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("result %0d: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                     results_seen, attitude_want.heading_deg,
                                     attitude_want.heading_centideg,
                                     attitude_want.pitch_deg, attitude_want.roll_deg,
                                     heading_deg, heading_centideg, pitch_deg, roll_deg);
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial
    begin
        int batch;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Noise in idle, then a frame whose look mode changes after the heading
        // bytes; the header value appears as data and as the trailing byte.
        pending_bytes.push_back(8'h55);
        pending_bytes.push_back(HDR_BYTE);
        pending_bytes.push_back(8'h80);
        pending_bytes.push_back(8'h00);
        wait_until_quiet();
        set_look(LOOK_EAST);
        pending_bytes.push_back(8'h7F);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(HDR_BYTE);
        pending_bytes.push_back(8'h01);
        pending_bytes.push_back(HDR_BYTE);
        wait_until_quiet();
        // Zero heading looking south lands on the upper edge of the range.
        set_look(LOOK_SOUTH);
        push_frame(16'h0000, 16'hFFFF, 16'h0063, 8'hFF);
        wait_until_quiet();
        set_look(LOOK_WEST);
        push_frame(16'h7FFF, 16'hFF9C, 16'h8000, 8'h00);

        for (batch = 0; batch < 6; batch++)
        begin
            wait_until_quiet();
            set_look(batch_look[batch]);
            send_idle_pct = (batch < 2) ? 36 : (batch < 4) ? 66 : 0;
            recv_idle_pct = (batch < 2) ? 66 : (batch < 4) ? 36 : 0;
            queue_random_traffic(170);
        end
        wait_until_quiet();

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #(200_000 * 12);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ihfd_pkg.sv
hw/rtl/ihfd_frame_asm.sv
hw/rtl/ihfd_angle_calc.sv
hw/rtl/imu_heading_frame_decoder_core.sv
test/imu_heading_frame_decoder_core_test.sv
